@@ sv/mctb_pkg.sv @@
// ============================================================================
// Timeout bank package
// Shared types, widths, command codes and the per-channel default periods.
// ============================================================================
package mctb_pkg;

    localparam int MAX_CHANNELS         = 16;
    localparam int DEFAULT_NUM_CHANNELS = 16;
    localparam int CH_W                 = 4;
    localparam int TIME_W               = 32;
    localparam int CNT_W                = 5;
    localparam int CMD_W                = 3;

    // Stream payload layout.
    localparam int IN_TDATA_USED  = CH_W + TIME_W + 1;
    localparam int IN_TDATA_W     = ((IN_TDATA_USED + 7) / 8) * 8;
    localparam int OUT_TDATA_USED = CH_W + TIME_W + TIME_W + 1 + 1 + CNT_W + TIME_W;
    localparam int OUT_TDATA_W    = ((OUT_TDATA_USED + 7) / 8) * 8;
    localparam int OUT_PAD_W      = OUT_TDATA_W - OUT_TDATA_USED;

    localparam logic EV_STATUS = 1'b0;
    localparam logic EV_EXPIRY = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK      = 3'd0,
        CMD_CONFIGURE = 3'd1,
        CMD_START     = 3'd2,
        CMD_STOP      = 3'd3,
        CMD_RESTART   = 3'd4,
        CMD_STOP_ALL  = 3'd5,
        CMD_QUERY     = 3'd6
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RMW,
        ST_REM,
        ST_RESP,
        ST_WALK,
        ST_EV_RD,
        ST_EV_OUT
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] start;
    } t_entry;

    typedef struct packed {
        logic              wr_en;
        logic [CH_W-1:0]   wr_addr;
        t_entry            wr_data;
        logic              rd_en;
        logic [CH_W-1:0]   rd_addr;
    } t_mem_req;

    typedef struct packed {
        logic [CH_W-1:0]   ch;
        logic [TIME_W-1:0] elapsed;
        logic              is_active;
        logic              has_expired;
    } t_event;

    typedef struct packed {
        logic              wr_en;
        logic [CH_W-1:0]   wr_addr;
        t_event            wr_data;
        logic              rd_en;
        logic [CH_W-1:0]   rd_addr;
    } t_evq_req;

    typedef struct packed {
        logic              kind;
        logic [CH_W-1:0]   ch;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] remaining;
        logic              is_active;
        logic              has_expired;
        logic [CNT_W-1:0]  active_count;
        logic [TIME_W-1:0] expiry_count;
        logic              last;
    } t_result;

    function automatic logic [TIME_W-1:0] default_period(input logic [CH_W-1:0] ch);
        logic [TIME_W-1:0] p;
        unique case (ch)
            4'd0:    p = 32'd5000;
            4'd1:    p = 32'd100;
            4'd2:    p = 32'd1000;
            4'd3:    p = 32'd500;
            4'd4:    p = 32'd5000;
            4'd5:    p = 32'd10000;
            4'd6:    p = 32'd100;
            4'd7:    p = 32'd1000;
            4'd8:    p = 32'd30000;
            4'd9:    p = 32'd50;
            default: p = 32'd1000;
        endcase
        return p;
    endfunction

endpackage

@@ sv/mctb_chan_mem.sv @@
// ============================================================================
// Timeout bank channel memory
// One entry per channel holding period and start time. Synchronous write,
// registered read. Entries never written since reset read as the defaults.
// ============================================================================
module mctb_chan_mem
    import mctb_pkg::*;
#(
    parameter int NUM_CHANNELS = DEFAULT_NUM_CHANNELS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mem_req i_req,
    output t_entry   o_rd_data
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    t_entry                  r_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_written;
    t_entry                  r_rd_data;
    logic                    r_rd_hit;
    logic [CH_W-1:0]         r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr[IDX_W-1:0]] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr[IDX_W-1:0]];
            r_rd_hit  <= r_written[i_req.rd_addr[IDX_W-1:0]];
            r_rd_addr <= i_req.rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_req.wr_en) begin
            r_written[i_req.wr_addr[IDX_W-1:0]] <= 1'b1;
        end
    end

    // The controller never reads and writes the same entry in one cycle,
    // so no bypass is needed here.
    always_comb begin
        if (r_rd_hit) begin
            o_rd_data = r_rd_data;
        end else begin
            o_rd_data.period = default_period(r_rd_addr);
            o_rd_data.start  = '0;
        end
    end

endmodule

@@ sv/mctb_evq.sv @@
// ============================================================================
// Timeout bank expiry queue
// Holds the expiry events of one tick until the walk over all channels is
// done, so that every beat carries the final counts of the step.
// ============================================================================
module mctb_evq
    import mctb_pkg::*;
#(
    parameter int NUM_CHANNELS = DEFAULT_NUM_CHANNELS
) (
    input  logic     i_clk,
    input  t_evq_req i_req,
    output t_event   o_rd_data
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    t_event r_mem [NUM_CHANNELS];
    t_event r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr[IDX_W-1:0]] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr[IDX_W-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/mctb_ctrl.sv @@
// ============================================================================
// Timeout bank controller
// Sequencer for the channel commands: read-modify-write of one channel entry,
// the tick walk over all channels and the emission of the result beats.
// ============================================================================
module mctb_ctrl
    import mctb_pkg::*;
#(
    parameter int NUM_CHANNELS = DEFAULT_NUM_CHANNELS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [CH_W-1:0]   i_ch,
    input  logic [TIME_W-1:0] i_period,
    input  logic              i_recurring,
    output t_mem_req          o_mem_req,
    input  t_entry            i_mem_rd,
    output t_evq_req          o_evq_req,
    input  t_event            i_evq_rd,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_result           o_res
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int QC_W  = IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(NUM_CHANNELS - 1);
    localparam logic [CH_W:0]    NUM_CH_LIM = (CH_W + 1)'(NUM_CHANNELS);

    t_state r_state, n_state;

    t_cmd                    r_cmd;
    logic [CH_W-1:0]         r_ch;
    logic [TIME_W-1:0]       r_per_in;
    logic                    r_rec_in;
    logic [TIME_W-1:0]       r_now;
    logic [TIME_W-1:0]       r_expiry_total;
    logic [NUM_CHANNELS-1:0] r_active;
    logic [NUM_CHANNELS-1:0] r_recur;
    logic [CNT_W-1:0]        r_active_count;
    logic [IDX_W-1:0]        r_idx;
    logic                    r_rd_done;
    logic                    r_ev_vld;
    logic [IDX_W-1:0]        r_ev_idx;
    logic [QC_W-1:0]         r_ev_cnt;
    logic [QC_W-1:0]         r_rd_ptr;
    logic [TIME_W-1:0]       r_p;
    logic [TIME_W-1:0]       r_e;
    logic                    r_act;
    t_result                 r_resp;

    logic              accept;
    t_cmd              in_cmd;
    logic              in_ch_ok;
    logic              in_single;
    logic [IDX_W-1:0]  ci;

    // Single-channel update datapath.
    logic              act_old;
    logic              act_new;
    logic [TIME_W-1:0] p_new;
    logic [TIME_W-1:0] s_new;
    logic [TIME_W-1:0] e_new;
    logic [TIME_W:0]   rem_diff;
    logic              reached;

    // Tick walk datapath.
    logic [TIME_W-1:0] ev_e;
    logic              ev_hit;
    logic              ev_rec;
    logic              walk_end;
    logic              ev_last;

    assign accept    = i_in_valid && o_in_ready;
    assign in_cmd    = t_cmd'(i_cmd);
    assign in_ch_ok  = {1'b0, i_ch} < NUM_CH_LIM;
    assign ci        = r_ch[IDX_W-1:0];

    always_comb begin
        unique case (in_cmd)
            CMD_CONFIGURE, CMD_START, CMD_STOP, CMD_RESTART, CMD_QUERY: in_single = 1'b1;
            default:                                                     in_single = 1'b0;
        endcase
    end

    always_comb begin
        act_old = r_active[ci];
        act_new = act_old;
        p_new   = i_mem_rd.period;
        s_new   = i_mem_rd.start;
        unique case (r_cmd)
            CMD_CONFIGURE: p_new = r_per_in;
            CMD_START: begin
                if (!act_old) begin
                    s_new   = r_now;
                    act_new = 1'b1;
                end
            end
            CMD_STOP:      act_new = 1'b0;
            CMD_RESTART: begin
                s_new   = r_now;
                act_new = 1'b1;
            end
            default: ;
        endcase
        e_new = r_now - s_new;
    end

    // Remaining time: one subtract whose borrow, or a zero result, also tells elapsed >= period.
    assign rem_diff = {1'b0, r_p} - {1'b0, r_e};
    assign reached  = rem_diff[TIME_W] || (rem_diff[TIME_W-1:0] == '0);

    assign ev_e     = r_now - i_mem_rd.start;
    assign ev_hit   = r_ev_vld && r_active[r_ev_idx] && (ev_e >= i_mem_rd.period);
    assign ev_rec   = r_recur[r_ev_idx];
    assign walk_end = r_ev_vld && (r_ev_idx == LAST_IDX);
    assign ev_last  = (r_rd_ptr + QC_W'(1)) == r_ev_cnt;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (in_cmd == CMD_TICK) begin
                        n_state = ST_WALK;
                    end else if (in_single && in_ch_ok) begin
                        n_state = ST_RMW;
                    end else begin
                        n_state = ST_RESP;
                    end
                end
            end
            ST_RMW: n_state = ST_REM;
            ST_REM: n_state = ST_RESP;
            ST_RESP: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            ST_WALK: begin
                if (walk_end) begin
                    if (r_ev_cnt == '0 && !ev_hit) begin
                        n_state = ST_RESP;
                    end else begin
                        n_state = ST_EV_RD;
                    end
                end
            end
            ST_EV_RD: n_state = ST_EV_OUT;
            ST_EV_OUT: begin
                if (i_res_ready) begin
                    n_state = ev_last ? ST_IDLE : ST_EV_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_ready  = 1'b0;
        o_mem_req   = '0;
        o_evq_req   = '0;
        o_res_valid = 1'b0;
        o_res       = r_resp;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready        = 1'b1;
                o_mem_req.rd_en   = accept && in_single && in_ch_ok;
                o_mem_req.rd_addr = i_ch;
            end
            ST_RMW: begin
                o_mem_req.wr_en        = 1'b1;
                o_mem_req.wr_addr      = r_ch;
                o_mem_req.wr_data      = '{period: p_new, start: s_new};
            end
            ST_RESP: o_res_valid = 1'b1;
            ST_WALK: begin
                o_mem_req.rd_en   = !r_rd_done;
                o_mem_req.rd_addr = CH_W'(r_idx);
                // A recurring expiry reloads the start time of the entry just read.
                o_mem_req.wr_en   = ev_hit && ev_rec;
                o_mem_req.wr_addr = CH_W'(r_ev_idx);
                o_mem_req.wr_data = '{period: i_mem_rd.period, start: r_now};
                o_evq_req.wr_en   = ev_hit;
                o_evq_req.wr_addr = CH_W'(r_ev_cnt[IDX_W-1:0]);
                o_evq_req.wr_data = '{ch: CH_W'(r_ev_idx), elapsed: ev_e, is_active: ev_rec,
                                      has_expired: ev_rec && (i_mem_rd.period == '0)};
            end
            ST_EV_RD: begin
                o_evq_req.rd_en   = 1'b1;
                o_evq_req.rd_addr = CH_W'(r_rd_ptr[IDX_W-1:0]);
            end
            ST_EV_OUT: begin
                o_res_valid       = 1'b1;
                o_res.kind        = EV_EXPIRY;
                o_res.ch          = i_evq_rd.ch;
                o_res.elapsed     = i_evq_rd.elapsed;
                o_res.remaining   = '0;
                o_res.is_active   = i_evq_rd.is_active;
                o_res.has_expired = i_evq_rd.has_expired;
                o_res.last        = ev_last;
            end
            default: ;
        endcase
        o_res.active_count = r_active_count;
        o_res.expiry_count = r_expiry_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_now          <= '0;
            r_expiry_total <= '0;
            r_active       <= '0;
            r_recur        <= '0;
            r_active_count <= '0;
            r_rd_done      <= 1'b0;
            r_ev_vld       <= 1'b0;
            r_ev_cnt       <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_cmd    <= in_cmd;
                        r_ch     <= i_ch;
                        r_per_in <= i_period;
                        r_rec_in <= i_recurring;
                        // Out-of-range channels still echo the channel number.
                        r_resp   <= '{kind: EV_STATUS, ch: in_single ? i_ch : '0,
                                      elapsed: '0, remaining: '0,
                                      is_active: 1'b0, has_expired: 1'b0,
                                      active_count: '0, expiry_count: '0, last: 1'b1};
                        if (in_cmd == CMD_TICK) begin
                            r_now     <= r_now + TIME_W'(1);
                            r_idx     <= '0;
                            r_rd_done <= 1'b0;
                            r_ev_vld  <= 1'b0;
                            r_ev_cnt  <= '0;
                        end else if (in_cmd == CMD_STOP_ALL) begin
                            r_active       <= '0;
                            r_active_count <= '0;
                        end
                    end
                end
                ST_RMW: begin
                    r_p         <= p_new;
                    r_e         <= e_new;
                    r_act       <= act_new;
                    r_active[ci] <= act_new;
                    if (r_cmd == CMD_CONFIGURE) begin
                        r_recur[ci] <= r_rec_in;
                    end
                    if (act_new && !act_old) begin
                        r_active_count <= r_active_count + CNT_W'(1);
                    end else if (!act_new && act_old) begin
                        r_active_count <= r_active_count - CNT_W'(1);
                    end
                end
                ST_REM: begin
                    r_resp.elapsed     <= r_e;
                    r_resp.remaining   <= reached ? '0 : rem_diff[TIME_W-1:0];
                    r_resp.is_active   <= r_act;
                    r_resp.has_expired <= r_act && reached;
                end
                ST_WALK: begin
                    r_ev_vld <= !r_rd_done;
                    if (!r_rd_done) begin
                        r_ev_idx <= r_idx;
                        if (r_idx == LAST_IDX) begin
                            r_rd_done <= 1'b1;
                        end else begin
                            r_idx <= r_idx + IDX_W'(1);
                        end
                    end
                    if (ev_hit) begin
                        r_ev_cnt       <= r_ev_cnt + QC_W'(1);
                        r_expiry_total <= r_expiry_total + TIME_W'(1);
                        if (!ev_rec) begin
                            r_active[r_ev_idx] <= 1'b0;
                            r_active_count     <= r_active_count - CNT_W'(1);
                        end
                    end
                    r_rd_ptr <= '0;
                end
                ST_EV_OUT: begin
                    if (i_res_ready) begin
                        r_rd_ptr <= r_rd_ptr + QC_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

@@ sv/multi_channel_timeout_bank_core.sv @@
// ============================================================================
// Multi-channel timeout bank
// Millisecond timeout channels with one-shot or recurring expiry, driven by a
// command stream and answering with status and expiry beats.
// ============================================================================
// Each input beat carries one command (tuser): tick, configure, start, stop,
// restart, stop all or query. Periods and start times live in a channel
// memory with one read and one write port and a registered read; entries
// never configured use the built-in default periods. A tick advances the
// millisecond counter and walks all NUM_CHANNELS entries, one memory read per
// cycle, then sends its expiry beats, each read back from a small event
// memory before it is offered (expiries are queued there during the walk and
// sent afterwards so every beat carries the final active and expiry counts),
// or the single status beat when nothing expired. Single-channel commands,
// stop all and the unused command code each give exactly one beat. The next
// command is taken once the last beat of the previous one has moved into the
// output register. tlast marks the last beat of each command.
module multi_channel_timeout_bank_core
    import mctb_pkg::*;
#(
    parameter int NUM_CHANNELS = DEFAULT_NUM_CHANNELS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [3:0] channel, [35:4] period_ms, [36] recurring, rest zero
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [2:0] command
    input  logic [CMD_W-1:0]       i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [3:0] channel_out, [35:4] elapsed_ms, [67:36] remaining_ms, [68] is_active,
    // [69] has_expired, [74:70] active_count, [106:75] expiry_count, rest zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // [0] event_kind
    output logic [0:0]             o_m_axis_tuser,
    output logic                   o_m_axis_tlast
);

    t_mem_req mem_req;
    t_entry   mem_rd;
    t_evq_req evq_req;
    t_event   evq_rd;
    logic     res_valid;
    logic     res_ready;
    t_result  res;

    logic    r_out_valid;
    t_result r_out;

    mctb_chan_mem #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_chan_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (mem_rd)
    );

    mctb_evq #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_evq (
        .i_clk     (i_clk),
        .i_req     (evq_req),
        .o_rd_data (evq_rd)
    );

    mctb_ctrl #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_cmd       (i_s_axis_tuser),
        .i_ch        (i_s_axis_tdata[CH_W-1:0]),
        .i_period    (i_s_axis_tdata[CH_W+TIME_W-1:CH_W]),
        .i_recurring (i_s_axis_tdata[CH_W+TIME_W]),
        .o_mem_req   (mem_req),
        .i_mem_rd    (mem_rd),
        .o_evq_req   (evq_req),
        .i_evq_rd    (evq_rd),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // Output register: takes a new beat whenever it is empty or being drained.
    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out.expiry_count, r_out.active_count,
                              r_out.has_expired, r_out.is_active, r_out.remaining,
                              r_out.elapsed, r_out.ch};
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out.last;

`ifndef SYNTHESIS
    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser[0] == EV_STATUS) |-> o_m_axis_tlast)
        else $error("status beat without tlast");

    a_expiry_rem_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser[0] == EV_EXPIRY) |-> (r_out.remaining == '0))
        else $error("expiry beat with nonzero remaining time");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_out.active_count <= CNT_W'(NUM_CHANNELS)))
        else $error("active count exceeds channel count");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("command accepted while previous one still in work");

    a_no_accept_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !o_s_axis_tready)
        else $error("input ready while a result is pending");
`endif

endmodule

@@ bench/multi_channel_timeout_bank_core_test.sv @@
// ============================================================================
// Timeout bank testbench
// Drives command beats into multi_channel_timeout_bank_core and checks every
// status and expiry beat against a cycle-free model of the channel bank.
// Directed tests cover reset periods, one-shot and recurring channels, field
// extremes and a whole-bank expiry. Random traffic runs under four
// flow-control phases.
// ============================================================================
module multi_channel_timeout_bank_core_test;
    import mctb_pkg::*;

    localparam int                NUM_CH       = DEFAULT_NUM_CHANNELS;
    localparam int                STALL_LIMIT  = 2000;
    localparam int                DRAIN_CYCLES = 40;
    localparam logic [CMD_W-1:0]  CMD_RESERVED = 3'd7;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_data = '0;
    logic [CMD_W-1:0]       s_user = CMD_TICK;
    logic                   s_ready;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_data;
    logic [0:0]             m_user;
    logic                   m_last;

    // Flow-control knobs, in percent per cycle.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    // Channel bank as the bench sees it.
    logic [TIME_W-1:0] ms_now;
    logic [TIME_W-1:0] chan_period [NUM_CH];
    logic [TIME_W-1:0] chan_start [NUM_CH];
    logic              chan_active [NUM_CH];
    logic              chan_recur [NUM_CH];
    logic [TIME_W-1:0] expiry_tally;

    t_result     results_due [$];
    int unsigned errors = 0;
    int unsigned commands_sent = 0;
    int unsigned beats_seen = 0;
    int unsigned expiries_seen = 0;
    int unsigned quiet_cycles = 0;

    multi_channel_timeout_bank_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Model of the bank
    // ------------------------------------------------------------------
    task automatic reset_bank();
        ms_now = '0;
        expiry_tally = '0;
        for (int i = 0; i < NUM_CH; i++) begin
            chan_period[i] = 32'd1000;
            chan_start[i] = '0;
            chan_active[i] = 1'b0;
            chan_recur[i] = 1'b0;
        end
        chan_period[0] = 32'd5000;
        chan_period[1] = 32'd100;
        chan_period[3] = 32'd500;
        chan_period[4] = 32'd5000;
        chan_period[5] = 32'd10000;
        chan_period[6] = 32'd100;
        chan_period[8] = 32'd30000;
        chan_period[9] = 32'd50;
    endtask

    function automatic logic [TIME_W-1:0] elapsed_ms_of(input int ch);
        return ms_now - chan_start[ch];
    endfunction

    function automatic logic [TIME_W-1:0] remaining_ms_of(input int ch);
        logic [TIME_W-1:0] el;
        el = elapsed_ms_of(ch);
        return (el >= chan_period[ch]) ? '0 : chan_period[ch] - el;
    endfunction

    function automatic logic timed_out(input int ch);
        return chan_active[ch] && (elapsed_ms_of(ch) >= chan_period[ch]);
    endfunction

    // Applies one command to the bank and queues the beats it must produce.
    task automatic predict_results(input logic [CMD_W-1:0] cmd, input logic [CH_W-1:0] ch,
                                   input logic [TIME_W-1:0] per, input logic rec);
        t_result           beats [$];
        t_result           r;
        logic [TIME_W-1:0] el;
        logic [CNT_W-1:0]  live;
        r = '0;
        case (cmd)
            CMD_TICK: begin
                ms_now = ms_now + TIME_W'(1);
                for (int i = 0; i < NUM_CH; i++) begin
                    if (timed_out(i)) begin
                        el = elapsed_ms_of(i);
                        expiry_tally = expiry_tally + TIME_W'(1);
                        expiries_seen++;
                        if (chan_recur[i]) chan_start[i] = ms_now;
                        else chan_active[i] = 1'b0;
                        r = '0;
                        r.kind = EV_EXPIRY;
                        r.ch = CH_W'(i);
                        r.elapsed = el;
                        r.is_active = chan_active[i];
                        r.has_expired = timed_out(i);
                        beats.push_back(r);
                    end
                end
                if (beats.size() == 0) begin
                    r = '0;
                    beats.push_back(r);
                end
            end
            CMD_STOP_ALL, CMD_RESERVED: begin
                if (cmd == CMD_STOP_ALL)
                    for (int i = 0; i < NUM_CH; i++) chan_active[i] = 1'b0;
                beats.push_back(r);
            end
            default: begin
                case (cmd)
                    CMD_CONFIGURE: begin
                        chan_period[ch] = per;
                        chan_recur[ch] = rec;
                    end
                    CMD_START: begin
                        if (!chan_active[ch]) begin
                            chan_start[ch] = ms_now;
                            chan_active[ch] = 1'b1;
                        end
                    end
                    CMD_STOP: chan_active[ch] = 1'b0;
                    CMD_RESTART: begin
                        chan_start[ch] = ms_now;
                        chan_active[ch] = 1'b1;
                    end
                    default: ;
                endcase
                r.kind = EV_STATUS;
                r.ch = ch;
                r.elapsed = elapsed_ms_of(ch);
                r.remaining = remaining_ms_of(ch);
                r.is_active = chan_active[ch];
                r.has_expired = timed_out(ch);
                beats.push_back(r);
            end
        endcase
        live = '0;
        for (int i = 0; i < NUM_CH; i++) live = live + CNT_W'(chan_active[i]);
        foreach (beats[k]) begin
            beats[k].active_count = live;
            beats[k].expiry_count = expiry_tally;
            beats[k].last = (k == beats.size() - 1);
            results_due.push_back(beats[k]);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus side
    // ------------------------------------------------------------------
    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [CH_W-1:0] ch,
                                input logic [TIME_W-1:0] per, input logic rec);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge i_clk);
        end
        s_valid = 1'b1;
        s_user = cmd;
        s_data = '0;
        s_data[CH_W-1:0] = ch;
        s_data[CH_W +: TIME_W] = per;
        s_data[CH_W + TIME_W] = rec;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        predict_results(cmd, ch, per, rec);
        commands_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (results_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_reset_periods();
        send_command(CMD_QUERY, 4'd0, '0, 1'b0);
        send_command(CMD_QUERY, 4'd3, '0, 1'b0);
        send_command(CMD_QUERY, 4'd8, '0, 1'b0);
        send_command(CMD_QUERY, 4'd9, '0, 1'b0);
        send_command(CMD_QUERY, 4'd15, '0, 1'b0);
        wait_drained();
    endtask

    // Channel 1 fires once after two ticks and stops; channel 2 has a zero
    // period and fires on every tick.
    task automatic test_one_shot_and_recurring();
        send_command(CMD_CONFIGURE, 4'd1, 32'd2, 1'b0);
        send_command(CMD_START, 4'd1, '0, 1'b0);
        send_command(CMD_CONFIGURE, 4'd2, 32'd0, 1'b1);
        send_command(CMD_RESTART, 4'd2, '0, 1'b0);
        repeat (3) send_command(CMD_TICK, 4'd0, '0, 1'b0);
        send_command(CMD_QUERY, 4'd1, '0, 1'b0);
        send_command(CMD_STOP, 4'd2, '0, 1'b0);
        send_command(CMD_STOP, 4'd2, '0, 1'b0);
        wait_drained();
    endtask

    task automatic test_field_extremes();
        send_command(CMD_CONFIGURE, 4'd15, 32'hFFFF_FFFF, 1'b1);
        send_command(CMD_START, 4'd15, '0, 1'b0);
        send_command(CMD_TICK, 4'd0, '0, 1'b0);
        send_command(CMD_START, 4'd15, '0, 1'b0);
        send_command(CMD_RESTART, 4'd15, '0, 1'b0);
        send_command(CMD_QUERY, 4'd15, 32'hFFFF_FFFF, 1'b1);
        send_command(CMD_STOP_ALL, 4'd15, '0, 1'b0);
        send_command(CMD_RESERVED, 4'd15, 32'hFFFF_FFFF, 1'b1);
        send_command(CMD_TICK, 4'd0, '0, 1'b0);
        wait_drained();
    endtask

    // Every channel expiring on one tick gives the longest burst of beats.
    task automatic test_full_bank_expiry();
        for (int i = 0; i < NUM_CH; i++)
            send_command(CMD_CONFIGURE, CH_W'(i), 32'($urandom_range(1)), 1'($urandom));
        for (int i = 0; i < NUM_CH; i++)
            send_command(CMD_RESTART, CH_W'(i), '0, 1'b0);
        repeat (2) send_command(CMD_TICK, 4'd0, '0, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count);
        int unsigned       roll;
        logic [CMD_W-1:0]  cmd;
        logic [TIME_W-1:0] per;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 40) cmd = CMD_TICK;
            else if (roll < 55) cmd = CMD_CONFIGURE;
            else if (roll < 67) cmd = CMD_START;
            else if (roll < 75) cmd = CMD_STOP;
            else if (roll < 85) cmd = CMD_RESTART;
            else if (roll < 88) cmd = CMD_STOP_ALL;
            else if (roll < 98) cmd = CMD_QUERY;
            else cmd = CMD_RESERVED;
            // Mostly short periods so channels actually expire.
            roll = $urandom_range(99);
            if (roll < 70) per = $urandom_range(6);
            else if (roll < 80) per = $urandom_range(40);
            else per = $urandom;
            send_command(cmd, CH_W'($urandom_range(15)), per, 1'($urandom));
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                   input logic [TIME_W-1:0] want);
        $display("[%0t] beat %0d: %s is 0x%0h, expected 0x%0h", $realtime, beats_seen,
                 what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_valid && m_ready) begin
            got = '0;
            got.kind = m_user[0];
            got.ch = m_data[3:0];
            got.elapsed = m_data[35:4];
            got.remaining = m_data[67:36];
            got.is_active = m_data[68];
            got.has_expired = m_data[69];
            got.active_count = m_data[74:70];
            got.expiry_count = m_data[106:75];
            got.last = m_last;
            if (results_due.size() == 0) begin
                report_mismatch("unexpected beat, channel", TIME_W'(got.ch), '0);
            end else begin
                want = results_due.pop_front();
                if (got.kind != want.kind)
                    report_mismatch("event_kind", TIME_W'(got.kind), TIME_W'(want.kind));
                if (got.ch != want.ch)
                    report_mismatch("channel", TIME_W'(got.ch), TIME_W'(want.ch));
                if (got.elapsed != want.elapsed)
                    report_mismatch("elapsed_ms", got.elapsed, want.elapsed);
                if (got.remaining != want.remaining)
                    report_mismatch("remaining_ms", got.remaining, want.remaining);
                if (got.is_active != want.is_active)
                    report_mismatch("is_active", TIME_W'(got.is_active),
                                    TIME_W'(want.is_active));
                if (got.has_expired != want.has_expired)
                    report_mismatch("has_expired", TIME_W'(got.has_expired),
                                    TIME_W'(want.has_expired));
                if (got.active_count != want.active_count)
                    report_mismatch("active_count", TIME_W'(got.active_count),
                                    TIME_W'(want.active_count));
                if (got.expiry_count != want.expiry_count)
                    report_mismatch("expiry_count", got.expiry_count, want.expiry_count);
                if (got.last != want.last)
                    report_mismatch("tlast", TIME_W'(got.last), TIME_W'(want.last));
            end
            beats_seen++;
        end
    end

    // Ends the run if no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        reset_bank();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_periods();
        test_one_shot_and_recurring();
        test_field_extremes();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_traffic(64);
        send_idle_pct = 57;
        test_random_traffic(64);
        send_idle_pct = 0;
        recv_stall_pct = 57;
        test_random_traffic(64);
        send_idle_pct = 36;
        recv_stall_pct = 36;
        test_full_bank_expiry();
        test_random_traffic(64);

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (results_due.size() != 0) begin
            $display("%0d expected beats never arrived", results_due.size());
            errors++;
        end
        $display("Sent %0d commands and checked %0d beats, %0d of them expiries,",
                 commands_sent, beats_seen, expiries_seen);
        $display("across idle-free, sender-idle, receiver-stall and mixed phases.");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/mctb_pkg.sv
sv/mctb_chan_mem.sv
sv/mctb_evq.sv
sv/mctb_ctrl.sv
sv/multi_channel_timeout_bank_core.sv
bench/multi_channel_timeout_bank_core_test.sv
